### hdl/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared opcodes, status codes and controller/datapath handshake types for
// the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned CAP_W    = 5;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [OP_W-1:0]          t_opcode;
    typedef logic [STATUS_W-1:0]      t_status;
    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [COUNT_W-1:0]       t_count;
    typedef logic [CAP_W-1:0]         t_cap;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the incoming item
        logic exec;      // carry out the latched opcode
        logic pop_out;   // present the popped word
        logic dump_out;  // present one dump entry, fetch the next if any
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_pop;
        logic is_dump;
        logic empty;
        logic dump_last;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

### hdl/bdq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_if
// Valid/ready channels for the deque: the command channel and the result
// channel.
// ----------------------------------------------------------------------------
interface bdq_in_if;
    logic                 valid;
    logic                 ready;
    bdq_pkg::t_opcode     opcode;
    bdq_pkg::t_word       push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface bdq_out_if;
    logic                 valid;
    logic                 ready;
    bdq_pkg::t_status     status;
    bdq_pkg::t_word       data_word;
    bdq_pkg::t_count      entry_count;
    logic                 last_of_run;

    modport source (output valid, output status, output data_word,
                    output entry_count, output last_of_run, input ready);
    modport sink   (input valid, input status, input data_word,
                    input entry_count, input last_of_run, output ready);
endinterface
`default_nettype wire

### hdl/bounded_double_ended_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_unit
// Bounded deque of signed 32-bit words held in a ring of DEPTH entries.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries opcode/push_value, o_out carries status, data_word,
//   entry_count and last_of_run; both are valid/ready channels. The capacity
//   register is written through i_cfg_wr_en/i_cfg_wr_data; the user must
//   write it only while idle, which the block does not enforce. An item is
//   taken in the idle state and executed in the exec state once the output
//   register is free; a push or failed removal loads its result there, a pop
//   first passes through the registered ring read port. No new item is taken
//   until the last is through; a dump gives one entry per cycle through that
//   port while the receiver takes them. Opcodes 5 to 7 give no result. The
//   next item is taken while a result still waits in the output register.
//   When the receiver stalls, the result holds and the walk of a dump waits.
//   Reset empties the queue and sets the capacity to 16 at once; the ring
//   store itself is not cleared, since only held entries are read.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    bdq_in_if.sink              i_in,
    bdq_out_if.source           o_out,
    input  wire logic           i_cfg_wr_en,
    input  wire bdq_pkg::t_cap  i_cfg_wr_data
);

    bdq_pkg::t_dp_cmd  cmd;
    bdq_pkg::t_dp_stat stat;
    logic              in_ready;
    logic              out_valid;
    bdq_pkg::t_status  out_status;
    bdq_pkg::t_word    out_data;
    bdq_pkg::t_count   out_count;
    logic              out_last;

    bdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_opcode      (i_in.opcode),
        .i_push_value  (i_in.push_value),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (out_valid),
        .i_out_ready   (o_out.ready),
        .o_status      (out_status),
        .o_data_word   (out_data),
        .o_entry_count (out_count),
        .o_last_of_run (out_last)
    );

    assign i_in.ready        = in_ready;
    assign o_out.valid       = out_valid;
    assign o_out.status      = out_status;
    assign o_out.data_word   = out_data;
    assign o_out.entry_count = out_count;
    assign o_out.last_of_run = out_last;

endmodule
`default_nettype wire

### hdl/bdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer for the deque: takes an item, runs it through the datapath and
// steps a dump one entry per result transfer.
// ----------------------------------------------------------------------------
module bdq_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire bdq_pkg::t_dp_stat  i_stat,
    output bdq_pkg::t_dp_cmd        o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;
    localparam logic [1:0] S_DUMP = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    if (i_stat.is_pop && !i_stat.empty) begin
                        n_state = S_POP;
                    end else if (i_stat.is_dump && !i_stat.empty) begin
                        n_state = S_DUMP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_POP: begin
                // read data lands this cycle
                if (i_stat.out_free) begin
                    o_cmd.pop_out = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_DUMP: begin
                if (i_stat.out_free) begin
                    o_cmd.dump_out = 1'b1;
                    if (i_stat.dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    // the output slot is always free on the cycle after an exec that read
    a_pop_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> i_stat.out_free)
        else $error("pop result found output slot busy");
`endif

endmodule
`default_nettype wire

### hdl/bdq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_datapath
// Ring store, head/count pointers, capacity register, read register and the
// result output register.
// ----------------------------------------------------------------------------
module bdq_datapath #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bdq_pkg::t_dp_cmd   i_cmd,
    output bdq_pkg::t_dp_stat       o_stat,
    input  wire bdq_pkg::t_opcode   i_opcode,
    input  wire bdq_pkg::t_word     i_push_value,
    input  wire logic               i_cfg_wr_en,
    input  wire bdq_pkg::t_cap      i_cfg_wr_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output bdq_pkg::t_status        o_status,
    output bdq_pkg::t_word          o_data_word,
    output bdq_pkg::t_count         o_entry_count,
    output logic                    o_last_of_run
);

    localparam int unsigned IW   = $clog2(DEPTH);
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = (CW > bdq_pkg::CAP_W) ? CW : bdq_pkg::CAP_W;

    logic [IW-1:0]       r_head;
    logic [IW-1:0]       n_head;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [IW-1:0]       r_rd_ptr;
    logic [IW-1:0]       n_rd_ptr;
    logic [CW-1:0]       r_left;
    logic [CW-1:0]       n_left;
    bdq_pkg::t_cap       r_cap;
    bdq_pkg::t_opcode    r_op;
    bdq_pkg::t_word      r_val;
    bdq_pkg::t_word      r_rd_data;
    bdq_pkg::t_word      r_mem [DEPTH];

    logic                mem_we;
    logic [IW-1:0]       mem_wa;
    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    logic                load;
    bdq_pkg::t_status    ld_status;
    bdq_pkg::t_word      ld_data;
    bdq_pkg::t_count     ld_count;
    logic                ld_last;
    logic                full;
    logic                empty;
    logic                out_free;
    logic [IW-1:0]       tail_idx;
    logic [IW-1:0]       back_idx;

    function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] idx);
        return (idx == IW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] idx);
        return (idx == '0) ? IW'(DEPTH - 1) : idx - 1'b1;
    endfunction

    // sum is below twice the depth, so one conditional subtract wraps it
    function automatic logic [IW-1:0] ring_wrap(input logic [IW:0] sum);
        return (sum >= (IW+1)'(DEPTH)) ? IW'(sum - (IW+1)'(DEPTH)) : IW'(sum);
    endfunction

    assign empty    = (r_count == '0);
    assign full     = (CMPW'(r_count) >= CMPW'(r_cap)) || (r_count == CW'(DEPTH));
    assign out_free = !o_out_valid || i_out_ready;
    assign tail_idx = ring_wrap((IW+1)'(r_head) + (IW+1)'(r_count));
    assign back_idx = ring_wrap((IW+1)'(r_head) + (IW+1)'(r_count) - 1'b1);

    assign o_stat.is_pop    = (r_op == bdq_pkg::OP_POP_FRONT) ||
                              (r_op == bdq_pkg::OP_POP_BACK);
    assign o_stat.is_dump   = (r_op == bdq_pkg::OP_DUMP);
    assign o_stat.empty     = empty;
    assign o_stat.dump_last = (r_left == CW'(1));
    assign o_stat.out_free  = out_free;

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_rd_ptr  = r_rd_ptr;
        n_left    = r_left;
        mem_we    = 1'b0;
        mem_wa    = r_head;
        rd_en     = 1'b0;
        rd_addr   = r_head;
        load      = 1'b0;
        ld_status = bdq_pkg::ST_OK;
        ld_data   = '0;
        ld_count  = bdq_pkg::COUNT_W'(r_count);
        ld_last   = 1'b1;
        priority if (i_cmd.exec) begin
            unique case (r_op)
                bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
                    load = 1'b1;
                    if (full) begin
                        ld_status = bdq_pkg::ST_OVER;
                    end else begin
                        mem_we   = 1'b1;
                        n_count  = r_count + 1'b1;
                        ld_count = bdq_pkg::COUNT_W'(r_count + 1'b1);
                        if (r_op == bdq_pkg::OP_PUSH_FRONT) begin
                            n_head = ring_dec(r_head);
                            mem_wa = ring_dec(r_head);
                        end else begin
                            mem_wa = tail_idx;
                        end
                    end
                end
                bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
                    if (empty) begin
                        load      = 1'b1;
                        ld_status = bdq_pkg::ST_UNDER;
                    end else begin
                        rd_en   = 1'b1;
                        n_count = r_count - 1'b1;
                        if (r_op == bdq_pkg::OP_POP_FRONT) begin
                            rd_addr = r_head;
                            n_head  = ring_inc(r_head);
                        end else begin
                            rd_addr = back_idx;
                        end
                    end
                end
                bdq_pkg::OP_DUMP: begin
                    if (empty) begin
                        load      = 1'b1;
                        ld_status = bdq_pkg::ST_UNDER;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = r_head;
                        n_rd_ptr = ring_inc(r_head);
                        n_left   = r_count;
                    end
                end
                default: ; // unknown opcode: no change, no result
            endcase
        end else if (i_cmd.pop_out) begin
            load    = 1'b1;
            ld_data = r_rd_data;
        end else if (i_cmd.dump_out) begin
            load    = 1'b1;
            ld_data = r_rd_data;
            ld_last = (r_left == CW'(1));
            n_left  = r_left - 1'b1;
            if (r_left != CW'(1)) begin
                rd_en    = 1'b1;
                rd_addr  = r_rd_ptr;
                n_rd_ptr = ring_inc(r_rd_ptr);
            end
        end else begin
            load = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= r_val;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_val <= i_push_value;
        end
        r_rd_ptr <= n_rd_ptr;
        r_left   <= n_left;
        if (load) begin
            o_status      <= ld_status;
            o_data_word   <= ld_data;
            o_entry_count <= ld_count;
            o_last_of_run <= ld_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_cap       <= bdq_pkg::CAP_RESET;
            o_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond ring depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && !full && ((r_op == bdq_pkg::OP_PUSH_FRONT) ||
         (r_op == bdq_pkg::OP_PUSH_BACK))) |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted push did not grow the queue");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> out_free)
        else $error("result loaded over an untaken result");

    a_dump_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dump_out |-> (r_left != '0))
        else $error("dump step with no entries left");
`endif

endmodule
`default_nettype wire
